FILE: rtl/svc_pkg.sv
// svc_pkg: shared types and codes for the snapshot visibility check
// holds the chain link word, compare flags, status / hint / config codes and id order
// no dependencies
package svc_pkg;

	// status codes supplied with each id
	localparam logic [1:0] XS_CURRENT   = 2'd0;
	localparam logic [1:0] XS_RUNNING   = 2'd1;
	localparam logic [1:0] XS_COMMITTED = 2'd2;
	localparam logic [1:0] XS_ABORTED   = 2'd3;

	// hint bit positions
	localparam int H_INS_COMMITTED = 0;
	localparam int H_INS_INVALID   = 1;
	localparam int H_DEL_COMMITTED = 2;
	localparam int H_DEL_INVALID   = 3;
	localparam int H_LOCK_ONLY     = 4;
	localparam int H_MOVED_OFF     = 5;
	localparam int H_MOVED_IN      = 6;

	// configuration register indexes
	localparam logic [1:0] CFG_LOW_XID   = 2'd0;
	localparam logic [1:0] CFG_HIGH_XID  = 2'd1;
	localparam logic [1:0] CFG_COMMAND   = 2'd2;
	localparam logic [1:0] CFG_RUN_COUNT = 2'd3;

	// word handed from one cell to the next
	typedef struct packed {
		logic tok;
		logic hit_ins;
		logic hit_del;
	} chain_t;

	// registered compare results against the snapshot
	typedef struct packed {
		logic ins_after_low;
		logic ins_after_high;
		logic del_after_low;
		logic del_after_high;
		logic icmd_ge;
		logic dcmd_ge;
	} cmp_t;

	// circular id order (plain order when either id is below three): a follows or equals b
	function automatic logic follows_or_equals(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		if (a >= 32'd3 && b >= 32'd3) begin
			return !diff[31];
		end
		return a >= b;
	endfunction

endpackage

FILE: rtl/svc_cell.sv
// svc_cell: one slot of the running transaction table
// compares its id as the token passes and forwards the hit flags
// depends on svc_pkg
module svc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  logic [31:0]    wdata,
	input  logic           active,
	input  logic [31:0]    ins_id,
	input  logic [31:0]    del_id,
	input  svc_pkg::chain_t link_i,
	output svc_pkg::chain_t link_o
);
	import svc_pkg::*;

	logic [31:0] entry_q;
	chain_t      link_q;
	logic        probe;

	// slot storage, written by load words
	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= wdata;
		end
	end

	// match only while the token is here and the slot is counted
	assign probe = link_i.tok & active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.tok     <= link_i.tok;
			link_q.hit_ins <= link_i.hit_ins | (probe & (entry_q == ins_id));
			link_q.hit_del <= link_i.hit_del | (probe & (entry_q == del_id));
		end
	end

	assign link_o = link_q;

endmodule

FILE: rtl/svc_decide.sv
// svc_decide: visibility decision and hint update for one row version
// uses the registered snapshot compares and the table hits from the cell row
// depends on svc_pkg
module svc_decide (
	input  logic [6:0]    hint,
	input  logic [1:0]    ist,
	input  logic [1:0]    dst,
	input  logic [1:0]    mst,
	input  svc_pkg::cmp_t cmp,
	input  logic          hit_ins,
	input  logic          hit_del,
	output logic          vis,
	output logic [6:0]    hint_out
);
	import svc_pkg::*;

	logic       early;
	logic       early_vis;
	logic [6:0] early_h;
	logic [6:0] h1;
	logic       ins_hidden;
	logic       del_hidden;

	assign ins_hidden = cmp.ins_after_low & (cmp.ins_after_high | hit_ins);
	assign del_hidden = cmp.del_after_low & (cmp.del_after_high | hit_del);

	// inserter side: may settle the answer before any table lookup
	always_comb begin
		early     = 1'b0;
		early_vis = 1'b0;
		early_h   = hint;
		h1        = hint;
		if (!hint[H_INS_COMMITTED]) begin
			priority if (hint[H_INS_INVALID]) begin
				early = 1'b1;
			end else if (hint[H_MOVED_OFF]) begin
				unique case (mst)
					XS_CURRENT:   early = 1'b1;
					XS_RUNNING:   h1 = hint;
					XS_COMMITTED: begin
						early = 1'b1;
						early_h[H_INS_INVALID] = 1'b1;
					end
					default:      h1[H_INS_COMMITTED] = 1'b1;
				endcase
			end else if (hint[H_MOVED_IN]) begin
				unique case (mst)
					XS_CURRENT:   h1 = hint;
					XS_RUNNING:   early = 1'b1;
					XS_COMMITTED: h1[H_INS_COMMITTED] = 1'b1;
					default: begin
						early = 1'b1;
						early_h[H_INS_INVALID] = 1'b1;
					end
				endcase
			end else begin
				unique case (ist)
					XS_CURRENT: begin
						early     = 1'b1;
						early_vis = !cmp.icmd_ge &
							(hint[H_DEL_INVALID] | hint[H_LOCK_ONLY] | cmp.dcmd_ge);
					end
					XS_RUNNING:   early = 1'b1;
					XS_COMMITTED: h1[H_INS_COMMITTED] = 1'b1;
					default: begin
						early = 1'b1;
						early_h[H_INS_INVALID] = 1'b1;
					end
				endcase
			end
		end
	end

	// deleter side and final answer
	always_comb begin
		vis      = 1'b0;
		hint_out = h1;
		priority if (early) begin
			vis      = early_vis;
			hint_out = early_h;
		end else if (ins_hidden) begin
			vis = 1'b0;
		end else if (h1[H_DEL_INVALID] || h1[H_LOCK_ONLY]) begin
			vis = 1'b1;
		end else if (!h1[H_DEL_COMMITTED]) begin
			unique case (dst)
				XS_CURRENT: vis = cmp.dcmd_ge;
				XS_RUNNING: vis = 1'b1;
				XS_ABORTED: begin
					vis = 1'b1;
					hint_out[H_DEL_INVALID] = 1'b1;
				end
				default: begin
					vis = del_hidden;
					hint_out[H_DEL_COMMITTED] = 1'b1;
				end
			endcase
		end else begin
			vis = del_hidden;
		end
	end

endmodule

FILE: rtl/snapshot_visibility_check.sv
// snapshot_visibility_check: row version visibility against a snapshot
// load word: writes one table slot; its result strobes on the next cycle, one load per cycle while not busy
// check word: a token walks the row of TABLE_DEPTH cells, one cell a cycle; launch_q, the cells
//   and done_q lie between accept and result; busy holds new words off until the result strobes
// results are shown for one cycle on done; the receiver cannot stall
// arst_n clears control, configuration and result registers; table slots hold no value until loaded
module snapshot_visibility_check #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// command
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [5:0]  entry_index,
	input  logic [31:0] entry_xid,
	input  logic [6:0]  hint_bits,
	input  logic [31:0] inserter_xid,
	input  logic [31:0] deleter_xid,
	input  logic [31:0] mover_xid,
	input  logic [31:0] insert_cmd,
	input  logic [31:0] delete_cmd,
	input  logic [1:0]  inserter_status,
	input  logic [1:0]  deleter_status,
	input  logic [1:0]  mover_status,
	// result
	output logic        done,
	output logic        visible,
	output logic [6:0]  new_hint_bits,
	output logic        hints_changed
);
	import svc_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic        state_q;
	logic        launch_q;
	logic        done_q;
	logic        visible_q;
	logic [6:0]  hint_out_q;
	logic        changed_q;

	logic [31:0] low_q;
	logic [31:0] high_q;
	logic [31:0] cmd_q;
	logic [6:0]  count_q;

	logic [6:0]  hint_q;
	logic [31:0] ins_q;
	logic [31:0] del_q;
	logic [31:0] icmd_q;
	logic [31:0] dcmd_q;
	logic [1:0]  ist_q;
	logic [1:0]  dst_q;
	logic [1:0]  mst_q;
	cmp_t        cmp_q;

	logic        acc;
	logic        acc_load;
	logic        acc_check;
	logic        last_tok;
	logic        vis_d;
	logic [6:0]  hint_d;

	chain_t                 link [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] tok_vec;

	assign busy      = (state_q == S_WALK);
	assign acc       = start & !busy;
	assign acc_load  = acc & mode;
	assign acc_check = acc & !mode;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			high_q  <= '0;
			cmd_q   <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW_XID:  low_q   <= cfg_data;
				CFG_HIGH_XID: high_q  <= cfg_data;
				CFG_COMMAND:  cmd_q   <= cfg_data;
				default:      count_q <= cfg_data[6:0];
			endcase
		end
	end

	// check word capture
	always_ff @(posedge clk) begin
		if (acc_check) begin
			hint_q <= hint_bits;
			ins_q  <= inserter_xid;
			del_q  <= deleter_xid;
			icmd_q <= insert_cmd;
			dcmd_q <= delete_cmd;
			ist_q  <= inserter_status;
			dst_q  <= deleter_status;
			mst_q  <= mover_status;
		end
	end

	// snapshot compares, settled long before the token leaves the row
	always_ff @(posedge clk) begin
		cmp_q.ins_after_low  <= follows_or_equals(ins_q, low_q);
		cmp_q.ins_after_high <= follows_or_equals(ins_q, high_q);
		cmp_q.del_after_low  <= follows_or_equals(del_q, low_q);
		cmp_q.del_after_high <= follows_or_equals(del_q, high_q);
		cmp_q.icmd_ge        <= icmd_q >= cmd_q;
		cmp_q.dcmd_ge        <= dcmd_q >= cmd_q;
	end

	// row of table cells
	assign link[0] = '{tok: launch_q, hit_ins: 1'b0, hit_del: 1'b0};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		svc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.we     (acc_load && (32'(entry_index) == 32'(i))),
			.wdata  (entry_xid),
			.active (32'(count_q) > 32'(i)),
			.ins_id (ins_q),
			.del_id (del_q),
			.link_i (link[i]),
			.link_o (link[i+1])
		);
		assign tok_vec[i] = link[i+1].tok;
	end

	assign last_tok = link[TABLE_DEPTH].tok;

	svc_decide u_decide (
		.hint     (hint_q),
		.ist      (ist_q),
		.dst      (dst_q),
		.mst      (mst_q),
		.cmp      (cmp_q),
		.hit_ins  (link[TABLE_DEPTH].hit_ins),
		.hit_del  (link[TABLE_DEPTH].hit_del),
		.vis      (vis_d),
		.hint_out (hint_d)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= acc_check;
			unique case (state_q)
				S_IDLE: begin
					if (acc_check) begin
						state_q <= S_WALK;
					end
				end
				default: begin
					if (last_tok) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			visible_q  <= 1'b0;
			hint_out_q <= '0;
			changed_q  <= 1'b0;
		end else begin
			done_q <= acc_load | last_tok;
			if (acc_load) begin
				visible_q  <= 1'b0;
				hint_out_q <= '0;
				changed_q  <= 1'b0;
			end else if (last_tok) begin
				visible_q  <= vis_d;
				hint_out_q <= hint_d;
				changed_q  <= |(hint_d & ~hint_q);
			end
		end
	end

	assign done          = done_q;
	assign visible       = visible_q;
	assign new_hint_bits = hint_out_q;
	assign hints_changed = changed_q;

`ifndef ASSERT_OFF
	// a result never shows while a check is still walking
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// at most one token in the cell row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({launch_q, tok_vec})) else $error("more than one token in flight");

	// a load answers on the next cycle with an empty word
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> (done && !visible && new_hint_bits == 7'd0 && !hints_changed))
		else $error("load result missing or not empty");

	// token leaving the row gives the result and frees the block
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		last_tok |=> (done && !busy)) else $error("walk end without result");

	// an accepted check occupies the block
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_check |=> (busy && launch_q)) else $error("check not started");
`endif

endmodule

FILE: tb/sv/tb_snapshot_visibility_check.sv
`timescale 1ns / 100ps
// tb_snapshot_visibility_check: self-checking bench for the snapshot visibility check
// depends on svc_pkg and snapshot_visibility_check; predicts each result word in place
module tb_snapshot_visibility_check;
	import svc_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int QUIET_LIMIT = 1000;

	// one command word as sent to the block
	typedef struct packed {
		logic        load;
		logic [5:0]  slot;
		logic [31:0] slot_xid;
		logic [6:0]  hints;
		logic [31:0] ins_xid;
		logic [31:0] del_xid;
		logic [31:0] mov_xid;
		logic [31:0] ins_cmd;
		logic [31:0] del_cmd;
		logic [1:0]  ins_st;
		logic [1:0]  del_st;
		logic [1:0]  mov_st;
	} row_word_t;

	// expected result word
	typedef struct packed {
		logic       vis;
		logic [6:0] hints;
		logic       changed;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        start;
	logic        busy;
	logic        mode;
	logic [5:0]  entry_index;
	logic [31:0] entry_xid;
	logic [6:0]  hint_bits;
	logic [31:0] inserter_xid;
	logic [31:0] deleter_xid;
	logic [31:0] mover_xid;
	logic [31:0] insert_cmd;
	logic [31:0] delete_cmd;
	logic [1:0]  inserter_status;
	logic [1:0]  deleter_status;
	logic [1:0]  mover_status;
	logic        done;
	logic        visible;
	logic [6:0]  new_hint_bits;
	logic        hints_changed;

	// snapshot as the bench believes it to be
	logic [31:0] snap_low = '0;
	logic [31:0] snap_high = '0;
	logic [31:0] snap_cmd = '0;
	logic [6:0]  run_count = '0;
	logic [31:0] xid_table [TABLE_DEPTH];

	verdict_t pending_verdicts [$];
	int mismatches = 0;
	int n_checks = 0;
	int n_loads = 0;
	int n_visible = 0;
	int n_settings = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;

	snapshot_visibility_check #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.mode(mode),
		.entry_index(entry_index),
		.entry_xid(entry_xid),
		.hint_bits(hint_bits),
		.inserter_xid(inserter_xid),
		.deleter_xid(deleter_xid),
		.mover_xid(mover_xid),
		.insert_cmd(insert_cmd),
		.delete_cmd(delete_cmd),
		.inserter_status(inserter_status),
		.deleter_status(deleter_status),
		.mover_status(mover_status),
		.done(done),
		.visible(visible),
		.new_hint_bits(new_hint_bits),
		.hints_changed(hints_changed)
	);

	// clock starts low so the first rising edge falls inside reset
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// circular order on ids; small ids compare plainly
	function automatic logic id_at_or_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] gap;
		if (a < 32'd3 || b < 32'd3) return a >= b;
		gap = a - b;
		return $signed(gap) >= 0;
	endfunction

	// id not yet committed as far as the snapshot is concerned
	function automatic logic still_running(input logic [31:0] id);
		int n;
		int i;
		if (!id_at_or_after(id, snap_low)) return 1'b0;
		if (id_at_or_after(id, snap_high)) return 1'b1;
		n = (run_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(run_count);
		for (i = 0; i < n; i++)
			if (xid_table[i] == id) return 1'b1;
		return 1'b0;
	endfunction

	function automatic verdict_t settle(input logic vis, input logic [6:0] now,
			input logic [6:0] was);
		return {vis, now, |(now & ~was)};
	endfunction

	// visibility of one row version and the hints it leaves behind
	function automatic verdict_t judge_row(input row_word_t w);
		logic [6:0] h;
		h = w.hints;
		if (!h[H_INS_COMMITTED]) begin
			if (h[H_INS_INVALID]) return settle(1'b0, h, w.hints);
			if (h[H_MOVED_OFF]) begin
				// row moved away by vacuum: the mover's outcome decides
				if (w.mov_st == XS_CURRENT) return settle(1'b0, h, w.hints);
				if (w.mov_st == XS_COMMITTED) begin
					h[H_INS_INVALID] = 1'b1;
					return settle(1'b0, h, w.hints);
				end
				if (w.mov_st == XS_ABORTED) h[H_INS_COMMITTED] = 1'b1;
			end else if (h[H_MOVED_IN]) begin
				if (w.mov_st == XS_RUNNING) return settle(1'b0, h, w.hints);
				if (w.mov_st == XS_COMMITTED) h[H_INS_COMMITTED] = 1'b1;
				if (w.mov_st == XS_ABORTED) begin
					h[H_INS_INVALID] = 1'b1;
					return settle(1'b0, h, w.hints);
				end
			end else begin
				case (w.ins_st)
					XS_CURRENT: begin
						// own insert: only earlier commands are seen
						if (w.ins_cmd >= snap_cmd) return settle(1'b0, h, w.hints);
						if (h[H_DEL_INVALID] || h[H_LOCK_ONLY])
							return settle(1'b1, h, w.hints);
						return settle(w.del_cmd >= snap_cmd, h, w.hints);
					end
					XS_RUNNING: return settle(1'b0, h, w.hints);
					XS_COMMITTED: h[H_INS_COMMITTED] = 1'b1;
					default: begin
						h[H_INS_INVALID] = 1'b1;
						return settle(1'b0, h, w.hints);
					end
				endcase
			end
		end
		if (still_running(w.ins_xid)) return settle(1'b0, h, w.hints);
		if (h[H_DEL_INVALID] || h[H_LOCK_ONLY]) return settle(1'b1, h, w.hints);
		if (!h[H_DEL_COMMITTED]) begin
			case (w.del_st)
				XS_CURRENT: return settle(w.del_cmd >= snap_cmd, h, w.hints);
				XS_RUNNING: return settle(1'b1, h, w.hints);
				XS_ABORTED: begin
					h[H_DEL_INVALID] = 1'b1;
					return settle(1'b1, h, w.hints);
				end
				default: h[H_DEL_COMMITTED] = 1'b1;
			endcase
		end
		return settle(still_running(w.del_xid), h, w.hints);
	endfunction

	function automatic logic [6:0] hint_mask(input int pos);
		return 7'(1) << pos;
	endfunction

	// id somewhere inside the snapshot window
	function automatic logic [31:0] window_xid();
		logic [31:0] span;
		span = snap_high - snap_low;
		if (span == 0) return snap_low;
		return snap_low + ($urandom % span);
	endfunction

	// ids biased toward the window edges, table entries and small ids
	function automatic logic [31:0] pick_xid();
		case ($urandom_range(7))
			0, 1: return xid_table[$urandom_range(TABLE_DEPTH - 1)];
			2: return snap_low + $urandom_range(2) - 1;
			3: return snap_high + $urandom_range(2) - 1;
			4: return $urandom_range(3);
			5: return $urandom;
			default: return window_xid();
		endcase
	endfunction

	function automatic logic [31:0] pick_cmd();
		case ($urandom_range(5))
			0: return snap_cmd;
			1: return snap_cmd - 1;
			2: return snap_cmd + 1;
			3: return 32'd0;
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// drive one word, hold it until accepted, then record its expected result
	task automatic send_word(input row_word_t w);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= w.load;
		entry_index <= w.slot;
		entry_xid <= w.slot_xid;
		hint_bits <= w.hints;
		inserter_xid <= w.ins_xid;
		deleter_xid <= w.del_xid;
		mover_xid <= w.mov_xid;
		insert_cmd <= w.ins_cmd;
		delete_cmd <= w.del_cmd;
		inserter_status <= w.ins_st;
		deleter_status <= w.del_st;
		mover_status <= w.mov_st;
		do @(posedge clk); while (busy);
		if (w.load) begin
			xid_table[w.slot] = w.slot_xid;
			pending_verdicts.push_back('0);
			n_loads++;
		end else begin
			pending_verdicts.push_back(judge_row(w));
			if (pending_verdicts[$].vis) n_visible++;
			n_checks++;
		end
	endtask

	task automatic load_slot(input logic [5:0] slot, input logic [31:0] xid);
		row_word_t w;
		w = '0;
		w.load = 1'b1;
		w.slot = slot;
		w.slot_xid = xid;
		send_word(w);
	endtask

	task automatic send_row(input logic [6:0] hints, input logic [31:0] ins, del, mov,
			input logic [31:0] icmd, dcmd, input logic [1:0] ist, dst, mst);
		row_word_t w;
		w = '0;
		w.slot = 6'($urandom);
		w.slot_xid = $urandom;
		w.hints = hints;
		w.ins_xid = ins;
		w.del_xid = del;
		w.mov_xid = mov;
		w.ins_cmd = icmd;
		w.del_cmd = dcmd;
		w.ins_st = ist;
		w.del_st = dst;
		w.mov_st = mst;
		send_word(w);
	endtask

	// stop sending and let every outstanding word come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0 || busy);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_LOW_XID: snap_low = value;
			CFG_HIGH_XID: snap_high = value;
			CFG_COMMAND: snap_cmd = value;
			default: run_count = value[6:0];
		endcase
	endtask

	task automatic set_snapshot(input logic [31:0] low, high, cmd, input logic [6:0] count);
		wait_drained();
		write_reg(CFG_LOW_XID, low);
		write_reg(CFG_HIGH_XID, high);
		write_reg(CFG_COMMAND, cmd);
		// upper data bits are don't-care for the count register
		write_reg(CFG_RUN_COUNT, {25'($urandom), count});
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// fill the whole running table, extremes of slot and id included
	task automatic test_table_load();
		int i;
		sender_idle_pct = 0;
		for (i = 0; i < 5; i++) load_slot(6'(i), 32'(150 + 10 * i));
		for (i = 5; i < TABLE_DEPTH - 2; i++) load_slot(6'(i), 32'(1000 + i));
		load_slot(6'(TABLE_DEPTH - 2), 32'd0);
		load_slot(6'(TABLE_DEPTH - 1), 32'hFFFF_FFFF);
	endtask

	task automatic each_mover_status(input logic [6:0] hints);
		send_row(hints, 190, 50, 60, 0, 0, XS_COMMITTED, XS_RUNNING, XS_CURRENT);
		send_row(hints, 190, 50, 60, 0, 0, XS_COMMITTED, XS_RUNNING, XS_RUNNING);
		send_row(hints, 190, 50, 60, 0, 0, XS_COMMITTED, XS_RUNNING, XS_COMMITTED);
		send_row(hints, 190, 50, 60, 0, 0, XS_COMMITTED, XS_RUNNING, XS_ABORTED);
	endtask

	// directed walk through every decision of the visibility rules
	task automatic test_row_paths();
		logic [6:0] ins_done;
		ins_done = hint_mask(H_INS_COMMITTED);
		// window [100, 200), four running ids 150..180, scan command 10
		set_snapshot(100, 200, 10, 7'd4);
		send_row(hint_mask(H_INS_INVALID), 50, 50, 50, 0, 0,
			XS_COMMITTED, XS_COMMITTED, XS_COMMITTED);
		// moved rows under every mover outcome
		each_mover_status(hint_mask(H_MOVED_OFF));
		each_mover_status(hint_mask(H_MOVED_IN));
		// own insert: command ids against the scan
		send_row('0, 150, 50, 50, 10, 0, XS_CURRENT, XS_CURRENT, XS_RUNNING);
		send_row(hint_mask(H_DEL_INVALID), 150, 50, 50, 9, 0,
			XS_CURRENT, XS_CURRENT, XS_RUNNING);
		send_row(hint_mask(H_LOCK_ONLY), 150, 50, 50, 9, 0,
			XS_CURRENT, XS_CURRENT, XS_RUNNING);
		send_row('0, 150, 50, 50, 9, 10, XS_CURRENT, XS_CURRENT, XS_RUNNING);
		send_row('0, 150, 50, 50, 9, 0, XS_CURRENT, XS_CURRENT, XS_RUNNING);
		// inserter status with no hints yet
		send_row('0, 50, 50, 50, 0, 0, XS_RUNNING, XS_RUNNING, XS_CURRENT);
		send_row('0, 50, 50, 50, 0, 0, XS_ABORTED, XS_RUNNING, XS_CURRENT);
		send_row('0, 150, 50, 50, 0, 0, XS_COMMITTED, XS_RUNNING, XS_CURRENT);
		// committed inserter, then each deleter outcome
		send_row(ins_done, 250, 50, 50, 0, 0, XS_COMMITTED, XS_RUNNING, XS_CURRENT);
		send_row(ins_done, 190, 50, 50, 0, 5, XS_COMMITTED, XS_CURRENT, XS_CURRENT);
		send_row(ins_done, 190, 50, 50, 0, 0, XS_COMMITTED, XS_RUNNING, XS_CURRENT);
		send_row(ins_done, 190, 50, 50, 0, 0, XS_COMMITTED, XS_ABORTED, XS_CURRENT);
		send_row(ins_done, 190, 160, 50, 0, 0, XS_COMMITTED, XS_COMMITTED, XS_CURRENT);
		send_row(ins_done | hint_mask(H_DEL_COMMITTED), 190, 50, 50, 0, 0,
			XS_COMMITTED, XS_RUNNING, XS_CURRENT);
		// ids below three use plain unsigned order
		send_row(ins_done, 0, 2, 1, 0, 0, XS_COMMITTED, XS_COMMITTED, XS_CURRENT);
		// id far behind the window after wraparound
		send_row(ins_done, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			XS_COMMITTED, XS_ABORTED, XS_ABORTED);
		send_row(7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, XS_ABORTED, XS_ABORTED, XS_ABORTED);
	endtask

	// running count at, below and above the table size
	task automatic test_count_saturation();
		logic [27:0] counts;
		int i;
		counts = {7'd127, 7'd64, 7'd63, 7'd0};
		load_slot(6'(TABLE_DEPTH - 1), 32'd199);
		for (i = 0; i < 4; i++) begin
			set_snapshot(100, 200, 10, counts[i * 7 +: 7]);
			send_row(hint_mask(H_INS_COMMITTED), 199, 50, 50, 0, 0,
				XS_COMMITTED, XS_RUNNING, XS_RUNNING);
			send_row(hint_mask(H_INS_COMMITTED), 150, 50, 50, 0, 0,
				XS_COMMITTED, XS_RUNNING, XS_RUNNING);
		end
	endtask

	// one snapshot setting: reload the live part of the table, then random words
	task automatic run_phase(input logic [31:0] low, high, cmd, input logic [6:0] count,
			input int idle_pct, input int n_words);
		row_word_t w;
		int filled;
		int i;
		set_snapshot(low, high, cmd, count);
		sender_idle_pct = idle_pct;
		filled = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
		for (i = 0; i < filled; i++) load_slot(6'(i), window_xid());
		repeat (n_words) begin
			w.load = ($urandom_range(99) < 10);
			w.slot = 6'($urandom);
			w.slot_xid = $urandom_range(1) ? window_xid() : $urandom;
			case ($urandom_range(3))
				0: w.hints = '0;
				1: w.hints = 7'($urandom & $urandom);
				2: w.hints = hint_mask($urandom_range(6));
				default: w.hints = 7'($urandom);
			endcase
			w.ins_xid = pick_xid();
			w.del_xid = pick_xid();
			w.mov_xid = pick_xid();
			w.ins_cmd = pick_cmd();
			w.del_cmd = pick_cmd();
			w.ins_st = 2'($urandom);
			w.del_st = 2'($urandom);
			w.mov_st = 2'($urandom);
			send_word(w);
		end
	endtask

	task automatic test_random_rows();
		logic [31:0] lo;
		run_phase(32'd0, 32'd0, 32'd0, 7'd0, 18, 150);
		run_phase(32'hFFFF_FFF0, 32'd20, 32'hFFFF_FFFF, 7'd127, 18, 150);
		lo = $urandom;
		run_phase(lo, lo + $urandom_range(1, 500), $urandom, 7'd64, 79, 150);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 7'd1, 79, 150);
		run_phase(32'd3, 32'd200, 32'd100, 7'($urandom_range(TABLE_DEPTH)), 0, 150);
		lo = $urandom;
		run_phase(lo, lo + $urandom_range(1, 5000), $urandom,
			7'($urandom_range(TABLE_DEPTH)), 0, 150);
	endtask

	task automatic compare_field(input string name, input logic [6:0] want,
			input logic [6:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		verdict_t want;
		if (done === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result word with none outstanding (visible %0h hints %0h)",
					$time, visible, new_hint_bits);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("visible", 7'(want.vis), 7'(visible));
				compare_field("new_hint_bits", want.hints, new_hint_bits);
				compare_field("hints_changed", 7'(want.changed), 7'(hints_changed));
			end
		end
		if (!arst_n || done === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		start <= 1'b0;
		mode <= 1'b0;
		entry_index <= '0;
		entry_xid <= '0;
		hint_bits <= '0;
		inserter_xid <= '0;
		deleter_xid <= '0;
		mover_xid <= '0;
		insert_cmd <= '0;
		delete_cmd <= '0;
		inserter_status <= '0;
		deleter_status <= '0;
		mover_status <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_row_paths();
		test_count_saturation();
		test_random_rows();
		wait_drained();
		// room for any stray result word
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		$display("covered %0d row checks (%0d visible) and %0d table loads",
			n_checks, n_visible, n_loads);
		$display("across %0d snapshot settings, %0d mismatches", n_settings, mismatches);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
